// File: rtl/mcs_pkg.sv
`timescale 1ns / 1ps
package mcs_pkg;

	// Fixed field widths
	localparam int PRICE_W   = 32;
	localparam int ALPHA_W   = 17;
	localparam int VAL_W     = 33;
	localparam int DELTA_W   = VAL_W + 1;
	localparam int PROD_W    = DELTA_W + ALPHA_W + 1;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 104;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ALPHA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUY_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SELL_MODE    = 3'd4;

	// Register reset values
	localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = 17'd11916;
	localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = 17'd5243;
	localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = 17'd32768;

	// Sample counter codes
	localparam logic [1:0] CNT_NONE   = 2'd0;
	localparam logic [1:0] CNT_SEEDED = 2'd1;
	localparam logic [1:0] CNT_SIGNAL = 2'd2;

	// Crossing modes
	localparam logic MODE_LINE_CROSS = 1'b0;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic mul_fast;
		logic upd_fast;
		logic mul_slow;
		logic upd_slow;
		logic calc_dif;
		logic mul_sig;
		logic upd_sig;
		logic load_out;
	} mcs_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic seed;
		logic out_free;
	} mcs_status_t;

endpackage

// File: rtl/mcs_ctrl.sv
`timescale 1ns / 1ps
module mcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_valid,
	output logic               s_ready,
	input  mcs_pkg::mcs_status_t status,
	output mcs_pkg::mcs_cmd_t    cmd
);
	import mcs_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FAST  = 8'b0000_0010,
		S_SLOW  = 8'b0000_0100,
		S_SLOWU = 8'b0000_1000,
		S_DIF   = 8'b0001_0000,
		S_MSIG  = 8'b0010_0000,
		S_SIGU  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state: seeding words skip straight to the result.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (s_valid) state_d = S_FAST;
			S_FAST:  state_d = status.seed ? S_FIN : S_SLOW;
			S_SLOW:  state_d = S_SLOWU;
			S_SLOWU: state_d = S_DIF;
			S_DIF:   state_d = S_MSIG;
			S_MSIG:  state_d = S_SIGU;
			S_SIGU:  state_d = S_FIN;
			S_FIN:   if (status.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command decode
	assign s_ready      = (state_q == S_IDLE);
	assign cmd.load_in  = (state_q == S_IDLE) && s_valid;
	assign cmd.mul_fast = (state_q == S_FAST);
	assign cmd.upd_fast = (state_q == S_SLOW);
	assign cmd.mul_slow = (state_q == S_SLOW);
	assign cmd.upd_slow = (state_q == S_SLOWU);
	assign cmd.calc_dif = (state_q == S_DIF);
	assign cmd.mul_sig  = (state_q == S_MSIG);
	assign cmd.upd_sig  = (state_q == S_SIGU);
	assign cmd.load_out = (state_q == S_FIN) && status.out_free;

endmodule

// File: rtl/mcs_datapath.sv
`timescale 1ns / 1ps
module mcs_datapath #(
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mcs_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [mcs_pkg::ALPHA_W-1:0]         cfg_wdata,
	input  logic [mcs_pkg::PRICE_W-1:0]         in_price,
	input  logic                                in_restart,
	input  mcs_pkg::mcs_cmd_t                   cmd,
	output mcs_pkg::mcs_status_t                status,
	input  logic                                m_ready,
	output logic                                m_valid,
	output logic [mcs_pkg::OUT_DATA_W-1:0]      m_data
);
	import mcs_pkg::*;

	localparam int CW = (ALPHA_FRAC_BITS + 1 > ALPHA_W) ? ALPHA_FRAC_BITS + 1 : ALPHA_W;
	localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1} << ALPHA_FRAC_BITS;
	localparam logic signed [PROD_W-1:0] HALF_C =
		{{(PROD_W-1){1'b0}}, 1'b1} << (ALPHA_FRAC_BITS - 1);
	localparam logic signed [VAL_W-1:0] S33_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] S33_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// A weight above one acts as one.
	function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
		logic [CW-1:0] a_ext;
		a_ext = {{(CW-ALPHA_W){1'b0}}, a};
		if (a_ext > ONE_C)
			return ONE_C[ALPHA_W-1:0];
		return a;
	endfunction

	logic [ALPHA_W-1:0] fast_alpha_q, slow_alpha_q, signal_alpha_q;
	logic               buy_mode_q, sell_mode_q;

	logic [PRICE_W-1:0]      price_q;
	logic                    restart_q;
	logic [PRICE_W-1:0]      fast_avg_q, slow_avg_q;
	logic signed [VAL_W-1:0] sig_avg_q, dif_q;
	logic signed [VAL_W-1:0] last_dif_q, last_dea_q, last_hist_q;
	logic [1:0]              count_q;
	logic                    in_pos_q;
	logic signed [PROD_W-1:0] prod_q;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_dif_q, out_dea_q, out_hist_q;
	logic                    out_buy_q, out_sell_q, out_hold_q;

	logic                     seed;
	logic signed [DELTA_W-1:0] mul_delta;
	logic [ALPHA_W-1:0]       mul_alpha;
	logic signed [PROD_W-1:0] step;
	logic [PRICE_W-1:0]       avg_sel;
	logic signed [PROD_W:0]   price_sum;
	logic [PRICE_W-1:0]       price_new;
	logic signed [PROD_W:0]   sig_sum;
	logic                     sig_fits;
	logic signed [VAL_W-1:0]  sig_new;
	logic signed [DELTA_W-1:0] hist_wide;
	logic signed [VAL_W-1:0]  hist;
	logic                     buy, sell;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_alpha_q   <= FAST_ALPHA_RST;
			slow_alpha_q   <= SLOW_ALPHA_RST;
			signal_alpha_q <= SIGNAL_ALPHA_RST;
			buy_mode_q     <= 1'b1;
			sell_mode_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_FAST_ALPHA:   fast_alpha_q   <= cfg_wdata;
				REG_SLOW_ALPHA:   slow_alpha_q   <= cfg_wdata;
				REG_SIGNAL_ALPHA: signal_alpha_q <= cfg_wdata;
				REG_BUY_MODE:     buy_mode_q     <= cfg_wdata[0];
				REG_SELL_MODE:    sell_mode_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign seed            = restart_q || (count_q == CNT_NONE);
	assign status.seed     = seed;
	assign status.out_free = !out_valid_q || m_ready;

	// Shared multiplier operand selection
	always_comb begin
		mul_delta = $signed({2'b00, price_q}) - $signed({2'b00, fast_avg_q});
		mul_alpha = clamp_alpha(fast_alpha_q);
		if (cmd.mul_slow) begin
			mul_delta = $signed({2'b00, price_q}) - $signed({2'b00, slow_avg_q});
			mul_alpha = clamp_alpha(slow_alpha_q);
		end else if (cmd.mul_sig) begin
			mul_delta = $signed({dif_q[VAL_W-1], dif_q}) -
				$signed({sig_avg_q[VAL_W-1], sig_avg_q});
			mul_alpha = clamp_alpha(signal_alpha_q);
		end
	end

	// Rounded weighted step from the registered product
	assign step = (prod_q + HALF_C) >>> ALPHA_FRAC_BITS;

	// Price average update with saturation to the unsigned range
	assign avg_sel   = cmd.upd_slow ? slow_avg_q : fast_avg_q;
	assign price_sum = $signed({{(PROD_W+1-PRICE_W){1'b0}}, avg_sel}) +
		$signed({step[PROD_W-1], step});
	always_comb begin
		if (price_sum[PROD_W])
			price_new = '0;
		else if (|price_sum[PROD_W-1:PRICE_W])
			price_new = '1;
		else
			price_new = price_sum[PRICE_W-1:0];
	end

	// Signal average update with saturation to the signed range; the first update after seeding takes dif as it is
	assign sig_sum  = $signed({{(PROD_W+1-VAL_W){sig_avg_q[VAL_W-1]}}, sig_avg_q}) +
		$signed({step[PROD_W-1], step});
	assign sig_fits = (&sig_sum[PROD_W:VAL_W-1]) || !(|sig_sum[PROD_W:VAL_W-1]);
	always_comb begin
		if (count_q == CNT_SEEDED)
			sig_new = dif_q;
		else if (sig_fits)
			sig_new = sig_sum[VAL_W-1:0];
		else
			sig_new = sig_sum[PROD_W] ? S33_MIN : S33_MAX;
	end

	// Histogram and crossing detection
	assign hist_wide = $signed({dif_q[VAL_W-1], dif_q}) -
		$signed({sig_avg_q[VAL_W-1], sig_avg_q});
	always_comb begin
		if (hist_wide[DELTA_W-1] == hist_wide[VAL_W-1])
			hist = hist_wide[VAL_W-1:0];
		else
			hist = hist_wide[DELTA_W-1] ? S33_MIN : S33_MAX;
	end

	always_comb begin
		buy  = 1'b0;
		sell = 1'b0;
		if (!in_pos_q) begin
			if (buy_mode_q == MODE_LINE_CROSS)
				buy = (last_dif_q <= last_dea_q) && (dif_q > sig_avg_q);
			else
				buy = (last_hist_q <= 0) && (hist > 0);
		end else begin
			if (sell_mode_q == MODE_LINE_CROSS)
				sell = (last_dif_q >= last_dea_q) && (dif_q < sig_avg_q);
			else
				sell = (last_dif_q >= 0) && (dif_q < 0);
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			price_q   <= in_price;
			restart_q <= in_restart;
		end
		if (cmd.mul_fast || cmd.mul_slow || cmd.mul_sig)
			prod_q <= mul_delta * $signed({1'b0, mul_alpha});
		if (cmd.upd_fast)
			fast_avg_q <= price_new;
		if (cmd.upd_slow)
			slow_avg_q <= price_new;
		if (cmd.calc_dif)
			dif_q <= $signed({1'b0, fast_avg_q}) - $signed({1'b0, slow_avg_q});
		if (cmd.upd_sig)
			sig_avg_q <= sig_new;
		if (cmd.load_out) begin
			if (seed) begin
				fast_avg_q  <= price_q;
				slow_avg_q  <= price_q;
				sig_avg_q   <= '0;
				last_dif_q  <= '0;
				last_dea_q  <= '0;
				last_hist_q <= '0;
				out_dif_q   <= '0;
				out_dea_q   <= '0;
				out_hist_q  <= '0;
				out_buy_q   <= 1'b0;
				out_sell_q  <= 1'b0;
				out_hold_q  <= 1'b0;
			end else begin
				last_dif_q  <= dif_q;
				last_dea_q  <= sig_avg_q;
				last_hist_q <= hist;
				out_dif_q   <= dif_q;
				out_dea_q   <= sig_avg_q;
				out_hist_q  <= hist;
				out_buy_q   <= buy;
				out_sell_q  <= sell;
				out_hold_q  <= (in_pos_q || buy) && !sell;
			end
		end
	end

	// Series control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_NONE;
			in_pos_q <= 1'b0;
		end else if (cmd.upd_sig && count_q == CNT_SEEDED) begin
			count_q <= CNT_SIGNAL;
		end else if (cmd.load_out) begin
			if (seed) begin
				count_q  <= CNT_SEEDED;
				in_pos_q <= 1'b0;
			end else begin
				in_pos_q <= (in_pos_q || buy) && !sell;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = {2'b00, out_hold_q, out_sell_q, out_buy_q,
		out_hist_q, out_dea_q, out_dif_q};

	// The sample counter only uses its three defined codes.
	a_count_code: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("sample counter took an undefined code");

	// A seeding sample reports all zeros.
	a_seed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && seed |=> m_data == '0)
		else $error("seeding result is not zero");

	// Buy and sell never fire together.
	a_buy_sell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_buy_q && out_sell_q))
		else $error("buy and sell fired on one sample");

	// The position flag follows the signals.
	a_pos_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_buy_q || out_hold_q) && (!out_sell_q || !out_hold_q))
		else $error("holding flag disagrees with the signals");

endmodule

// File: rtl/macd_crossover_signal.sv
`timescale 1ns / 1ps
// MACD indicator with crossover trade signals.
// Input stream: one closing price per period in s_axis_tdata (unsigned Q16.16);
// s_axis_tuser set marks the first sample of a new series, which seeds the
// averages, clears the position and reports all-zero results.
// Output stream: one word per input word with dif, dea, hist and the
// buy, sell and holding flags.
// The configuration port writes the average weights and crossing modes; write
// it only while no sample is in flight.
// Sequencing: one multiplier is shared by the fast, slow and signal averages,
// so a normal sample steps through the FAST, SLOW, SLOWU, DIF, MSIG, SIGU and
// FIN states before its result is registered (a seeding sample goes from FAST
// straight to FIN), and the next word is accepted in the cycle after the result
// is registered; no new word is taken while a sample is in flight.
// Reset puts the weights and modes at their defaults and starts with no series,
// so the first sample seeds.  The output register holds its word until taken;
// a finished result waits for it to free, which holds off the next input word.
module macd_crossover_signal #(
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mcs_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [mcs_pkg::ALPHA_W-1:0]          cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [31:0] close_price
	input  logic [mcs_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// [0] restart
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [32:0] dif_out, [65:33] dea_out, [98:66] hist_out, [99] buy flag,
	// [100] sell flag, [101] holding, [103:102] zero
	output logic [mcs_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);
	import mcs_pkg::*;

	mcs_cmd_t    cmd;
	mcs_status_t status;

	mcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	mcs_datapath #(
		.ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_price   (s_axis_tdata[PRICE_W-1:0]),
		.in_restart (s_axis_tuser),
		.cmd        (cmd),
		.status     (status),
		.m_ready    (m_axis_tready),
		.m_valid    (m_axis_tvalid),
		.m_data     (m_axis_tdata)
	);

endmodule

// File: sim/tb_macd_crossover_signal.sv
`timescale 1ns / 1ps
module tb_macd_crossover_signal;
	import mcs_pkg::*;

	// Result word as it sits in m_axis_tdata[101:0], highest field first.
	typedef struct packed {
		logic                  hold;
		logic                  sell;
		logic                  buy;
		logic signed [VAL_W-1:0] hist;
		logic signed [VAL_W-1:0] dea;
		logic signed [VAL_W-1:0] dif;
	} macd_word_t;

	typedef enum logic {ROW_PRICE, ROW_REG} row_kind_t;

	// One step of the directed sequence: a price word or a register write.
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [ALPHA_W-1:0]     reg_val;
		logic [PRICE_W-1:0]     price;
		logic                   restart;
		logic                   known;
		macd_word_t             want;
	} plan_row_t;

	localparam int ALPHA_FRAC = 16;
	localparam longint ALPHA_ONE = 64'd1 << ALPHA_FRAC;
	localparam longint ALPHA_HALF = 64'd1 << (ALPHA_FRAC - 1);
	localparam longint PRICE_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam longint S33_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam longint S33_MIN = -64'sh0000_0001_0000_0000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam macd_word_t ALL_ZERO = '0;
	localparam int NUM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 235;
	localparam int CALM_PHASE = 3;
	localparam int PRESSURE_PHASE = 5;
	localparam int HOLD_CYCLES = 400;
	localparam int PLAN_LEN = 25;

	// Directed sequence. Seeding words and a flat second price are known to give zeros.
	localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
		'{ROW_PRICE, '0, '0, 32'h0010_0000, 1'b0, 1'b1, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0010_0000, 1'b0, 1'b1, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0020_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0030_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0000_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'hFFFF_FFFF, 1'b1, 1'b1, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0000_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0000_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_FAST_ALPHA, 17'h1FFFF, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_SLOW_ALPHA, 17'h00000, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_SIGNAL_ALPHA, 17'h10000, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_BUY_MODE, 17'h1FFFE, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_SELL_MODE, 17'h00002, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_SPARE_LO, 17'h00000, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_SPARE_HI, 17'h1FFFF, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h8000_0000, 1'b1, 1'b1, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h8001_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h8002_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_REG, REG_SIGNAL_ALPHA, 17'h04000, '0, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h8010_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h7000_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h9000_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'h0000_0000, 1'b0, 1'b0, ALL_ZERO},
		'{ROW_PRICE, '0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0, ALL_ZERO}
	};

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_addr = '0;
	logic [ALPHA_W-1:0]      cfg_wdata = '0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;

	// Predictor copy of the weights, modes and indicator state.
	longint     rate_fast, rate_slow, rate_signal;
	logic       mode_buy, mode_sell;
	longint     ema_fast, ema_slow, ema_sig;
	longint     prev_dif, prev_dea, prev_hist;
	logic [1:0] series_cnt;
	logic       holding_now;

	macd_word_t due_words [$];
	int         fail_count = 0;
	int         words_sent = 0;
	int         words_checked = 0;
	int         restarts_sent = 0;
	int         buys_seen = 0;
	int         sells_seen = 0;
	bit         calm = 1'b0;
	bit         hold_req = 1'b0;
	bit         hold_done = 1'b0;
	int         stall_left = 0;

	macd_crossover_signal uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Rounded weighted step of an average; weights above one act as one.
	function automatic longint ema_move(longint delta, longint alpha);
		longint a;
		a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
		return (delta * a + ALPHA_HALF) >>> ALPHA_FRAC;
	endfunction

	function automatic longint clamp33(longint v);
		if (v > S33_MAX)
			return S33_MAX;
		if (v < S33_MIN)
			return S33_MIN;
		return v;
	endfunction

	function automatic longint price_ema_next(longint avg, longint p, longint alpha);
		longint v;
		v = avg + ema_move(p - avg, alpha);
		if (v < 0)
			v = 0;
		if (v > PRICE_MAX)
			v = PRICE_MAX;
		return v;
	endfunction

	// Advances the indicator by one price and returns the word it should report.
	function automatic macd_word_t macd_step(logic [PRICE_W-1:0] price, logic restart);
		longint p, dif, dea, hist;
		logic buy, sell;
		macd_word_t w;
		p = {32'd0, price};
		w = '0;
		buy = 1'b0;
		sell = 1'b0;
		if (restart || series_cnt == CNT_NONE) begin
			ema_fast = p;
			ema_slow = p;
			ema_sig = 0;
			prev_dif = 0;
			prev_dea = 0;
			prev_hist = 0;
			series_cnt = CNT_SEEDED;
			holding_now = 1'b0;
			return w;
		end
		ema_fast = price_ema_next(ema_fast, p, rate_fast);
		ema_slow = price_ema_next(ema_slow, p, rate_slow);
		dif = ema_fast - ema_slow;
		if (series_cnt == CNT_SEEDED) begin
			ema_sig = dif;
			series_cnt = CNT_SIGNAL;
		end else begin
			ema_sig = clamp33(ema_sig + ema_move(dif - ema_sig, rate_signal));
		end
		dea = ema_sig;
		hist = clamp33(dif - dea);
		// Buy only while flat, sell only while holding.
		if (!holding_now) begin
			if (mode_buy == MODE_LINE_CROSS)
				buy = (prev_dif <= prev_dea) && (dif > dea);
			else
				buy = (prev_hist <= 0) && (hist > 0);
			if (buy)
				holding_now = 1'b1;
		end else begin
			if (mode_sell == MODE_LINE_CROSS)
				sell = (prev_dif >= prev_dea) && (dif < dea);
			else
				sell = (prev_dif >= 0) && (dif < 0);
			if (sell)
				holding_now = 1'b0;
		end
		prev_dif = dif;
		prev_dea = dea;
		prev_hist = hist;
		w.dif = dif[VAL_W-1:0];
		w.dea = dea[VAL_W-1:0];
		w.hist = hist[VAL_W-1:0];
		w.buy = buy;
		w.sell = sell;
		w.hold = holding_now;
		return w;
	endfunction

	function automatic logic [ALPHA_W-1:0] pick_alpha(int lo, int hi);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return ALPHA_ONE[ALPHA_W-1:0];
		if (r < 15)
			return ALPHA_W'($urandom_range(131071, 65537));
		return ALPHA_W'($urandom_range(hi, lo));
	endfunction

	function automatic longint jitter(longint s);
		return longint'($urandom_range(32'(2 * s))) - s;
	endfunction

	// Register write at a falling edge; the enable is then dropped again.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ALPHA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_FAST_ALPHA:   rate_fast = val;
			REG_SLOW_ALPHA:   rate_slow = val;
			REG_SIGNAL_ALPHA: rate_signal = val;
			REG_BUY_MODE:     mode_buy = val[0];
			REG_SELL_MODE:    mode_sell = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Stops offering and lets every expected word come out before a write.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Offers one price word, starting and ending at a falling edge.
	task automatic send_word(logic [PRICE_W-1:0] price, logic restart, logic known,
			macd_word_t want);
		macd_word_t w;
		while (!calm && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= price;
		s_axis_tuser <= restart;
		do
			@(posedge clk);
		while (!s_axis_tready);
		w = macd_step(price, restart);
		due_words.insert(due_words.size(), known ? want : w);
		words_sent++;
		if (restart)
			restarts_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Output side: random stalls, a calm stretch, and one long hold-off.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			stall_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 14);
		end
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		macd_word_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[101:0];
			if (due_words.size() == 0) begin
				$error("result word with no expectation waiting: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = due_words.pop_front();
				check_field("dif_out", want.dif, got.dif);
				check_field("dea_out", want.dea, got.dea);
				check_field("hist_out", want.hist, got.hist);
				check_field("buy_flag", want.buy, got.buy);
				check_field("sell_flag", want.sell, got.sell);
				check_field("holding", want.hold, got.hold);
				check_field("pad bits", 0, m_axis_tdata[103:102]);
				words_checked++;
				buys_seen += got.buy;
				sells_seen += got.sell;
			end
		end
	end

	// Stimulus: reset, directed sequence, then randomized phases.
	initial begin
		longint level, trend, span;
		logic restart;
		int roll;
		rate_fast = FAST_ALPHA_RST;
		rate_slow = SLOW_ALPHA_RST;
		rate_signal = SIGNAL_ALPHA_RST;
		mode_buy = 1'b1;
		mode_sell = 1'b1;
		ema_fast = 0;
		ema_slow = 0;
		ema_sig = 0;
		prev_dif = 0;
		prev_dea = 0;
		prev_hist = 0;
		series_cnt = CNT_NONE;
		holding_now = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (DIRECTED_PLAN[i]) begin
			if (DIRECTED_PLAN[i].kind == ROW_REG) begin
				settle();
				write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_val);
			end else begin
				send_word(DIRECTED_PLAN[i].price, DIRECTED_PLAN[i].restart,
					DIRECTED_PLAN[i].known, DIRECTED_PLAN[i].want);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			calm = (ph == CALM_PHASE);
			// The first two phases pin the weights and modes to their extremes.
			if (ph == 0) begin
				write_reg(REG_FAST_ALPHA, '0);
				write_reg(REG_SLOW_ALPHA, '0);
				write_reg(REG_SIGNAL_ALPHA, '0);
				write_reg(REG_BUY_MODE, 17'd0);
				write_reg(REG_SELL_MODE, 17'd0);
			end else if (ph == 1) begin
				write_reg(REG_FAST_ALPHA, 17'h1FFFF);
				write_reg(REG_SLOW_ALPHA, 17'd1);
				write_reg(REG_SIGNAL_ALPHA, ALPHA_ONE[ALPHA_W-1:0]);
				write_reg(REG_BUY_MODE, 17'd1);
				write_reg(REG_SELL_MODE, 17'd1);
			end else begin
				write_reg(REG_FAST_ALPHA, pick_alpha(4000, 30000));
				write_reg(REG_SLOW_ALPHA, pick_alpha(500, 6000));
				write_reg(REG_SIGNAL_ALPHA, pick_alpha(5000, 40000));
				write_reg(REG_BUY_MODE, ALPHA_W'($urandom_range(131071)));
				write_reg(REG_SELL_MODE, ALPHA_W'($urandom_range(131071)));
			end
			level = $urandom;
			span = 64'd1 << $urandom_range(28, 6);
			trend = jitter(span / 4);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if (ph == PRESSURE_PHASE && n == 40)
					hold_req <= 1'b1;
				restart = 1'b0;
				roll = $urandom_range(99);
				// Mostly trending random walks, with restarts and wild prices mixed in.
				if (roll < 3) begin
					restart = 1'b1;
					level = $urandom;
				end else if (roll < 7) begin
					level = $urandom;
				end else begin
					if ($urandom_range(99) < 6)
						trend = jitter(span / 4);
					level = level + trend + jitter(span);
					if (level < 0)
						level = 0;
					if (level > PRICE_MAX)
						level = PRICE_MAX;
				end
				send_word(level[PRICE_W-1:0], restart, 1'b0, ALL_ZERO);
			end
		end

		// Drain and give the block time to show any stray word.
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Ran %0d price words (%0d restarts) over %0d weight settings.",
			words_sent, restarts_sent, NUM_PHASES + 1);
		$display("Checked %0d result words with %0d buys and %0d sells.",
			words_checked, buys_seen, sells_seen);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
rtl/mcs_pkg.sv
rtl/mcs_ctrl.sv
rtl/mcs_datapath.sv
rtl/macd_crossover_signal.sv
sim/tb_macd_crossover_signal.sv
